// ===== hw/rtl/cwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwc_pkg: shared types, constants and lookup functions
// Codon translation tables, base classification and the ambiguous-codon key
// lookup for the codon window composition block.
// ----------------------------------------------------------------------------
package cwc_pkg;

   localparam int MaxLenDefault      = 65536;
   localparam int WindowBackDefault  = 57;
   localparam int WindowAheadDefault = 60;

   localparam int NumAmino   = 22;
   localparam int NumResults = 28;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Base classes.
   localparam logic [2:0] BASE_A     = 3'd0;
   localparam logic [2:0] BASE_C     = 3'd1;
   localparam logic [2:0] BASE_G     = 3'd2;
   localparam logic [2:0] BASE_T     = 3'd3;
   localparam logic [2:0] BASE_OTHER = 3'd4;

   // Amino slot meaning "not counted" (# and X).
   localparam logic [4:0] SLOT_NONE = 5'd22;

   // Scratch code for symbols that are not counted, outside every amino code.
   localparam logic [4:0] SCRATCH_NONE = 5'd31;

   // Feature codes.
   localparam logic [4:0] FEAT_GC    = 5'd0;
   localparam logic [4:0] FEAT_TOTAL = 5'd5;
   localparam logic [4:0] FEAT_AMINO = 5'd6;
   localparam logic [4:0] FEAT_LAST  = 5'd27;

   // Result of one codon translation, passed from the reader to the counter.
   typedef struct packed {
      logic       valid;
      logic [4:0] slot;
      logic [2:0] code0;
      logic [2:0] code1;
      logic [2:0] code2;
   } codon_type;

   function automatic logic [2:0] base_code(input logic [7:0] b);
      logic [2:0] r;
      case (b)
         8'h61:   r = BASE_A;
         8'h63:   r = BASE_C;
         8'h67:   r = BASE_G;
         8'h74:   r = BASE_T;
         default: r = BASE_OTHER;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] complement(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h61:   r = 8'h74;
         8'h74:   r = 8'h61;
         8'h63:   r = 8'h67;
         8'h67:   r = 8'h63;
         8'h62:   r = 8'h76;
         8'h76:   r = 8'h62;
         8'h64:   r = 8'h68;
         8'h68:   r = 8'h64;
         8'h6b:   r = 8'h6d;
         8'h6d:   r = 8'h6b;
         8'h72:   r = 8'h79;
         8'h79:   r = 8'h72;
         default: r = 8'h6e;
      endcase
      return r;
   endfunction

   // Remainder of a 16-bit value by three. Each pair of bits carries a weight
   // of one modulo three, so the pairs are summed and the sum folded again.
   function automatic logic [1:0] mod3(input logic [15:0] v);
      logic [4:0] s1;
      logic [2:0] s2;
      logic [2:0] s3;
      logic [1:0] r;
      s1 = '0;
      for (int i = 0; i < 8; i++) begin
         s1 = s1 + 5'(v[2*i +: 2]);
      end
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
      s3 = 3'(s2[1:0]) + 3'(s2[2]);
      r  = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
      return r;
   endfunction

   // Amino table index (0..64) to a scratch code, rising in the order
   // * + A C D E F G H I K L M N P Q R S T V W Y; # and X give SCRATCH_NONE.
   function automatic logic [4:0] rom_slot(input logic [6:0] idx);
      logic [4:0] r;
      case (idx)
         7'd0, 7'd2:                     r = 5'd12; // K
         7'd1, 7'd3:                     r = 5'd15; // N
         7'd4, 7'd5, 7'd6, 7'd7:         r = 5'd20; // T
         7'd8, 7'd10:                    r = 5'd18; // R
         7'd9, 7'd11:                    r = 5'd19; // S
         7'd12, 7'd13, 7'd15:            r = 5'd11; // I
         7'd14:                          r = 5'd14; // M
         7'd16, 7'd18:                   r = 5'd17; // Q
         7'd17, 7'd19:                   r = 5'd10; // H
         7'd20, 7'd21, 7'd22, 7'd23:     r = 5'd16; // P
         7'd24, 7'd25, 7'd26, 7'd27:     r = 5'd18; // R
         7'd28, 7'd29, 7'd30, 7'd31:     r = 5'd13; // L
         7'd32, 7'd34:                   r = 5'd7;  // E
         7'd33, 7'd35:                   r = 5'd6;  // D
         7'd36, 7'd37, 7'd38, 7'd39:     r = 5'd2;  // A
         7'd40, 7'd41, 7'd42, 7'd43:     r = 5'd9;  // G
         7'd44, 7'd45, 7'd46, 7'd47:     r = 5'd21; // V
         7'd49, 7'd51:                   r = 5'd23; // Y
         7'd50:                          r = 5'd1;  // +
         7'd52, 7'd53, 7'd54, 7'd55:     r = 5'd19; // S
         7'd56:                          r = 5'd0;  // *
         7'd57, 7'd59:                   r = 5'd3;  // C
         7'd58:                          r = 5'd22; // W
         7'd60, 7'd62:                   r = 5'd13; // L
         7'd61, 7'd63:                   r = 5'd8;  // F
         default:                        r = SCRATCH_NONE; // # and X
      endcase
      // Codes from D on sit two above their output slot; slot_fix folds them into order.
      return r;
   endfunction

   // Ambiguous codon key lookup; returns amino table index, 64 when unmatched.
   function automatic logic [6:0] key_lookup(input logic [23:0] key);
      logic [6:0] r;
      case (key)
         24'd7437682: r = 7'd0;
         24'd7892857: r = 7'd1;
         24'd7438192, 24'd7893367, 24'd6983017, 24'd7113067, 24'd6397792,
         24'd7698292, 24'd6527842, 24'd6787942: r = 7'd4;
         24'd7439212, 24'd6333799, 24'd6723949, 24'd7439224: r = 7'd8;
         24'd7894387, 24'd7438211, 24'd7893386, 24'd6983036, 24'd7113086,
         24'd6397811, 24'd7698311, 24'd6527861, 24'd6787961: r = 7'd9;
         24'd7897702, 24'd7117402, 24'd6792277: r = 7'd12;
         24'd7437684: r = 7'd16;
         24'd7892859: r = 7'd17;
         24'd7438194, 24'd7893369, 24'd6983019, 24'd7113069, 24'd6397794,
         24'd7698294, 24'd6527844, 24'd6787944: r = 7'd20;
         24'd7439214, 24'd7894389, 24'd6984039, 24'd7114089, 24'd6398814,
         24'd7699314, 24'd6528864, 24'd6788964: r = 7'd24;
         24'd7442529, 24'd7897704, 24'd6987354, 24'd7117404, 24'd6402129,
         24'd7702629, 24'd6532179, 24'd6792279, 24'd7442546, 24'd6337126,
         24'd6727276, 24'd7442551: r = 7'd28;
         24'd7437688: r = 7'd32;
         24'd7892863: r = 7'd33;
         24'd7438198, 24'd7893373, 24'd6983023, 24'd7113073, 24'd6397798,
         24'd7698298, 24'd6527848, 24'd6787948: r = 7'd36;
         24'd7439218, 24'd7894393, 24'd6984043, 24'd7114093, 24'd6398818,
         24'd7699318, 24'd6528868, 24'd6788968: r = 7'd40;
         24'd7442533, 24'd7897708, 24'd6987358, 24'd7117408, 24'd6402133,
         24'd7702633, 24'd6532183, 24'd6792283: r = 7'd44;
         24'd7437701, 24'd6336611: r = 7'd56;
         24'd7892876: r = 7'd49;
         24'd7894406: r = 7'd57;
         24'd7897721: r = 7'd61;
         default: r = 7'd64;
      endcase
      return r;
   endfunction

   // Slot order fix: the slot function above uses a 24-code scratch space;
   // map it into the 22 output slots * + A C D E F G H I K L M N P Q R S T V W Y.
   function automatic logic [4:0] slot_fix(input logic [4:0] s);
      logic [4:0] r;
      case (s)
         5'd0:    r = 5'd0;  // *
         5'd1:    r = 5'd1;  // +
         5'd2:    r = 5'd2;  // A
         5'd3:    r = 5'd3;  // C
         5'd6:    r = 5'd4;  // D
         5'd7:    r = 5'd5;  // E
         5'd8:    r = 5'd6;  // F
         5'd9:    r = 5'd7;  // G
         5'd10:   r = 5'd8;  // H
         5'd11:   r = 5'd9;  // I
         5'd12:   r = 5'd10; // K
         5'd13:   r = 5'd11; // L
         5'd14:   r = 5'd12; // M
         5'd15:   r = 5'd13; // N
         5'd16:   r = 5'd14; // P
         5'd17:   r = 5'd15; // Q
         5'd18:   r = 5'd16; // R
         5'd19:   r = 5'd17; // S
         5'd20:   r = 5'd18; // T
         5'd21:   r = 5'd19; // V
         5'd22:   r = 5'd20; // W
         5'd23:   r = 5'd21; // Y
         default: r = SLOT_NONE;
      endcase
      return r;
   endfunction

   // Translate three bytes (already in reading order) to a counting slot.
   function automatic logic [4:0] translate(input logic [7:0] x0,
                                            input logic [7:0] x1,
                                            input logic [7:0] x2);
      logic [2:0]  n0;
      logic [2:0]  n1;
      logic [2:0]  n2;
      logic [23:0] key;
      logic [6:0]  idx;
      n0 = base_code(x0);
      n1 = base_code(x1);
      n2 = base_code(x2);
      key = 24'(x0) + 24'(x1) * 24'd255 + 24'(x2) * 24'd65025;
      if (n0 != BASE_OTHER && n1 != BASE_OTHER && n2 != BASE_OTHER) begin
         idx = {1'b0, n0[1:0], n1[1:0], n2[1:0]};
      end else begin
         idx = key_lookup(key);
      end
      return slot_fix(rom_slot(idx));
   endfunction

endpackage

// ===== hw/rtl/cwc_seq_mem.sv =====
// ----------------------------------------------------------------------------
// cwc_seq_mem: sequence byte store
// Single-port synchronous memory, one write or one read per cycle, read data
// registered and available on the cycle after the address.
// ----------------------------------------------------------------------------
module cwc_seq_mem #(
   parameter int MaxLen = cwc_pkg::MaxLenDefault,
   localparam int AddrW = $clog2(MaxLen)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] addr,
   input  logic [7:0]       wr_data,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [MaxLen];
   logic [7:0] rd_data_ff;

   // Write port and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/codon_window_composition.sv =====
// ----------------------------------------------------------------------------
// codon_window_composition: sliding-window codon composition
// Stores DNA bytes, keeps whole-sequence base counts and reports window codon
// and base composition around a queried position as 28 fraction pairs.
// ----------------------------------------------------------------------------
// Append and clear beats are handled in the idle state. A query reads the
// window from the single-port sequence memory one byte per cycle, three
// bytes per codon, then emits its 28 result beats one per cycle as the
// consumer takes them; an out-of-range query gives one beat. Requests are
// taken one at a time: the next one is accepted once the previous query's
// last beat is in the output register.
module codon_window_composition #(
   parameter int MaxLen      = cwc_pkg::MaxLenDefault,
   parameter int WindowBack  = cwc_pkg::WindowBackDefault,
   parameter int WindowAhead = cwc_pkg::WindowAheadDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_base,
   input  logic [15:0] req_position,
   input  logic        req_strand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_feature,
   output logic [16:0] rsp_numerator,
   output logic [16:0] rsp_denominator,
   output logic        rsp_out_of_range,
   output logic        rsp_last
);

   localparam int AddrW = $clog2(MaxLen);
   localparam int LenW  = AddrW + 1;
   localparam int PosW  = LenW + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT,
      ST_OOR
   } state_type;

   // Control and state registers.
   state_type         state_ff;
   logic [LenW-1:0]   len_ff;
   logic [16:0]       gcnt_ff [5];
   logic [PosW-1:0]   rd_ptr_ff;
   logic [PosW-1:0]   hi_ff;
   logic [1:0]        rd_phase_ff;
   logic              rd_pend_ff;
   logic [1:0]        cap_phase_ff;
   logic              strand_ff;
   logic [7:0]        b0_ff;
   logic [7:0]        b1_ff;
   logic              reading_ff;
   logic [6:0]        amino_ff [cwc_pkg::NumAmino];
   logic [7:0]        wbase_ff [4];
   logic [7:0]        total_ff;
   logic [4:0]        emit_ff;
   logic              rsp_valid_ff;
   logic [4:0]        rsp_feature_ff;
   logic [16:0]       rsp_num_ff;
   logic [16:0]       rsp_den_ff;
   logic              rsp_oor_ff;
   logic              rsp_last_ff;

   logic              req_fire;
   logic              out_free;
   logic              rsp_load;
   logic [PosW-1:0]   pos_ext;
   logic [PosW-1:0]   pos_mod;
   logic [PosW-1:0]   lo_val;
   logic [PosW-1:0]   hi_val;
   logic [PosW-1:0]   len_m2;
   logic [PosW-1:0]   ahead;
   logic              mem_wr;
   logic [AddrW-1:0]  mem_addr;
   logic [7:0]        mem_rd;
   logic [7:0]        x0;
   logic [7:0]        x1;
   logic [7:0]        x2;
   cwc_pkg::codon_type codon;
   logic [16:0]       win_sum;
   logic [16:0]       gc_num;
   logic [16:0]       gc_den;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_EMIT || state_ff == ST_OOR) && out_free;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Window bounds; PosW bits hold position plus the look-ahead.
   assign pos_ext = PosW'(req_position);
   assign pos_mod = PosW'(cwc_pkg::mod3(req_position));
   assign lo_val  = (pos_ext > PosW'(WindowBack) + pos_mod)
                    ? pos_ext - PosW'(WindowBack) : pos_mod;
   assign len_m2  = PosW'(len_ff) - PosW'(2);
   assign ahead   = pos_ext + PosW'(WindowAhead);
   assign hi_val  = (ahead < len_m2) ? ahead : len_m2;

   // Memory port: appends write at the length, queries read the window.
   assign mem_wr   = req_fire && req_op == cwc_pkg::OP_APPEND
                     && len_ff < LenW'(MaxLen);
   assign mem_addr = mem_wr ? len_ff[AddrW-1:0] : rd_ptr_ff[AddrW-1:0];

   cwc_seq_mem #(.MaxLen(MaxLen)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .addr    (mem_addr),
      .wr_data (req_base),
      .rd_data (mem_rd)
   );

   // Codon translation on the third byte of each codon.
   always_comb begin
      if (strand_ff) begin
         x0 = b0_ff;
         x1 = b1_ff;
         x2 = mem_rd;
      end else begin
         x0 = cwc_pkg::complement(mem_rd);
         x1 = cwc_pkg::complement(b1_ff);
         x2 = cwc_pkg::complement(b0_ff);
      end
      codon.valid = rd_pend_ff && cap_phase_ff == 2'd2;
      codon.slot  = cwc_pkg::translate(x0, x1, x2);
      codon.code0 = cwc_pkg::base_code(b0_ff);
      codon.code1 = cwc_pkg::base_code(b1_ff);
      codon.code2 = cwc_pkg::base_code(mem_rd);
   end

   assign win_sum = 17'(wbase_ff[0]) + 17'(wbase_ff[1])
                    + 17'(wbase_ff[2]) + 17'(wbase_ff[3]);
   assign gc_num  = gcnt_ff[1] + gcnt_ff[2];
   assign gc_den  = gcnt_ff[0] + gcnt_ff[1] + gcnt_ff[2] + gcnt_ff[3];

   // Sequencer, counters and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         for (int i = 0; i < 5; i++) gcnt_ff[i] <= '0;
         rd_pend_ff   <= 1'b0;
         reading_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_op)
                     cwc_pkg::OP_APPEND: begin
                        if (mem_wr) begin
                           len_ff <= len_ff + LenW'(1);
                           gcnt_ff[cwc_pkg::base_code(req_base)] <=
                              gcnt_ff[cwc_pkg::base_code(req_base)] + 17'd1;
                        end
                     end
                     cwc_pkg::OP_CLEAR: begin
                        len_ff <= '0;
                        for (int i = 0; i < 5; i++) gcnt_ff[i] <= '0;
                     end
                     cwc_pkg::OP_QUERY: begin
                        strand_ff <= req_strand;
                        if (PosW'(req_position) + PosW'(2) >= PosW'(len_ff)) begin
                           state_ff <= ST_OOR;
                        end else begin
                           rd_ptr_ff   <= lo_val;
                           hi_ff       <= hi_val;
                           rd_phase_ff <= 2'd0;
                           reading_ff  <= lo_val < hi_val;
                           total_ff    <= '0;
                           for (int i = 0; i < cwc_pkg::NumAmino; i++) amino_ff[i] <= '0;
                           for (int i = 0; i < 4; i++) wbase_ff[i] <= '0;
                           state_ff    <= ST_READ;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_READ: begin
               // Issue one byte read a cycle while a codon start lies below hi.
               rd_pend_ff   <= reading_ff;
               cap_phase_ff <= rd_phase_ff;
               if (reading_ff) begin
                  rd_ptr_ff <= rd_ptr_ff + PosW'(1);
                  if (rd_phase_ff == 2'd2) begin
                     rd_phase_ff <= 2'd0;
                     reading_ff  <= rd_ptr_ff + PosW'(1) < hi_ff;
                  end else begin
                     rd_phase_ff <= rd_phase_ff + 2'd1;
                  end
               end
               // Capture returned bytes and count each finished codon.
               if (rd_pend_ff) begin
                  if (cap_phase_ff == 2'd0) b0_ff <= mem_rd;
                  if (cap_phase_ff == 2'd1) b1_ff <= mem_rd;
               end
               if (codon.valid) begin
                  total_ff <= total_ff + 8'd1;
                  if (codon.slot != cwc_pkg::SLOT_NONE) begin
                     amino_ff[codon.slot] <= amino_ff[codon.slot] + 7'd1;
                  end
                  for (int k = 0; k < 4; k++) begin
                     wbase_ff[k] <= wbase_ff[k]
                        + 8'(codon.code0 == 3'(k)) + 8'(codon.code1 == 3'(k))
                        + 8'(codon.code2 == 3'(k));
                  end
               end
               if (!reading_ff && !rd_pend_ff) begin
                  emit_ff  <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_feature_ff <= emit_ff;
                  rsp_oor_ff     <= 1'b0;
                  rsp_last_ff    <= emit_ff == cwc_pkg::FEAT_LAST;
                  if (emit_ff == cwc_pkg::FEAT_GC) begin
                     rsp_num_ff <= gc_num;
                     rsp_den_ff <= gc_den;
                  end else if (emit_ff < cwc_pkg::FEAT_TOTAL) begin
                     // Reverse strand swaps a with t and c with g.
                     rsp_num_ff <= 17'(wbase_ff[strand_ff ? emit_ff[1:0] - 2'd1
                                                          : 2'd3 - (emit_ff[1:0] - 2'd1)]);
                     rsp_den_ff <= win_sum;
                  end else if (emit_ff == cwc_pkg::FEAT_TOTAL) begin
                     rsp_num_ff <= 17'(total_ff);
                     rsp_den_ff <= 17'd1;
                  end else begin
                     rsp_num_ff <= 17'(amino_ff[5'(emit_ff - cwc_pkg::FEAT_AMINO)]);
                     rsp_den_ff <= 17'(total_ff);
                  end
                  if (emit_ff == cwc_pkg::FEAT_LAST) begin
                     state_ff <= ST_IDLE;
                  end
                  emit_ff <= emit_ff + 5'd1;
               end
            end
            ST_OOR: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_feature_ff <= cwc_pkg::FEAT_GC;
                  rsp_num_ff     <= '0;
                  rsp_den_ff     <= '0;
                  rsp_oor_ff     <= 1'b1;
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_feature      = rsp_feature_ff;
   assign rsp_numerator    = rsp_num_ff;
   assign rsp_denominator  = rsp_den_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_last         = rsp_last_ff;

   // The stored length never passes the memory capacity.
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LenW'(MaxLen)) else $error("sequence length over capacity");

   // Requests are never taken while a query is being worked on.
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("ready while busy");

   // An out-of-range beat is always the last of its run.
   a_oor_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_last) else $error("oor not last");

endmodule

// ===== test/codon_window_composition_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for codon_window_composition
// Drives append, query, clear and unused operation beats with bursty timing,
// predicts every result beat from an independent model of the window
// composition, and checks each result beat in order against that prediction.
// ----------------------------------------------------------------------------
module codon_window_composition_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         SeqCap    = 65536;
   localparam int         BackSpan  = 57;
   localparam int         AheadSpan = 60;
   localparam int         KeyCount  = 87;

   localparam string AminoTable =
      "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV#Y+YSSSS*CWCLFLFX";
   localparam string AminoOrder = "*+ACDEFGHIKLMNPQRSTVWY";

   localparam int unsigned AMBIG_KEY [KeyCount] = '{
      7437682, 7892857, 7438192, 7893367, 6983017, 7113067, 6397792, 7698292,
      6527842, 6787942, 7439212, 7894387, 7897702, 7117402, 6792277, 7437684,
      7892859, 7438194, 7893369, 6983019, 7113069, 6397794, 7698294, 6527844,
      6787944, 7439214, 7894389, 6984039, 7114089, 6398814, 7699314, 6528864,
      6788964, 7442529, 7897704, 6987354, 7117404, 6402129, 7702629, 6532179,
      6792279, 7437688, 7892863, 7438198, 7893373, 6983023, 7113073, 6397798,
      7698298, 6527848, 6787948, 7439218, 7894393, 6984043, 7114093, 6398818,
      7699318, 6528868, 6788968, 7442533, 7897708, 6987358, 7117408, 6402133,
      7702633, 6532183, 6792283, 7437701, 7892876, 7438211, 7893386, 6983036,
      7113086, 6397811, 7698311, 6527861, 6787961, 7894406, 7442546, 7897721,
      6336611, 6337126, 6727276, 7442551, 6333799, 6723949, 7439224
   };
   localparam int AMBIG_ROW [KeyCount] = '{
      0, 1, 4, 4, 4, 4, 4, 4, 4, 4, 8, 9, 12, 12, 12, 16,
      17, 20, 20, 20, 20, 20, 20, 20, 20, 24, 24, 24, 24, 24, 24, 24,
      24, 28, 28, 28, 28, 28, 28, 28, 28, 32, 33, 36, 36, 36, 36, 36,
      36, 36, 36, 40, 40, 40, 40, 40, 40, 40, 40, 44, 44, 44, 44, 44,
      44, 44, 44, 56, 49, 9, 9, 9, 9, 9, 9, 9, 9, 57, 28, 61,
      56, 28, 28, 28, 8, 8, 8
   };

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  base;
      logic [15:0] position;
      logic        strand;
      bit          hold;      // wait until every expected beat has arrived
   } request_type;

   typedef struct {
      logic [4:0]  feature;
      logic [16:0] numerator;
      logic [16:0] denominator;
      logic        out_of_range;
      logic        last;
   } composition_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = cwc_pkg::OP_APPEND;
   logic [7:0]  req_base = 8'h00;
   logic [15:0] req_position = 16'h0000;
   logic        req_strand = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_feature;
   logic [16:0] rsp_numerator;
   logic [16:0] rsp_denominator;
   logic        rsp_out_of_range;
   logic        rsp_last;

   request_type     pending_reqs[$];
   composition_type expected_beats[$];
   int              error_count = 0;
   bit              stimulus_done = 1'b0;

   // Predictor state.
   logic [7:0] seq_mem [0:SeqCap-1];
   int         seq_len = 0;
   int         whole_counts [5];

   codon_window_composition u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_base(req_base), .req_position(req_position), .req_strand(req_strand),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_feature(rsp_feature),
      .rsp_numerator(rsp_numerator), .rsp_denominator(rsp_denominator),
      .rsp_out_of_range(rsp_out_of_range), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic int nucleotide_code(logic [7:0] b);
      case (b)
         "a": return 0;
         "c": return 1;
         "g": return 2;
         "t": return 3;
         default: return 4;
      endcase
   endfunction

   function automatic logic [7:0] pair_base(logic [7:0] b);
      case (b)
         "a": return "t";
         "t": return "a";
         "c": return "g";
         "g": return "c";
         "b": return "v";
         "v": return "b";
         "d": return "h";
         "h": return "d";
         "k": return "m";
         "m": return "k";
         "r": return "y";
         "y": return "r";
         default: return "n";
      endcase
   endfunction

   // Returns the amino slot 0..21, or 22 for symbols that are not counted.
   function automatic int codon_slot(logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
      int          n0, n1, n2, row, s;
      int unsigned key;
      byte         sym;
      n0 = nucleotide_code(x0);
      n1 = nucleotide_code(x1);
      n2 = nucleotide_code(x2);
      row = 64;
      if (n0 < 4 && n1 < 4 && n2 < 4) begin
         row = n0 * 16 + n1 * 4 + n2;
      end else begin
         key = int'(x0) + int'(x1) * 255 + int'(x2) * 65025;
         for (int k = 0; k < KeyCount; k++) begin
            if (AMBIG_KEY[k] == key && row == 64) row = AMBIG_ROW[k];
         end
      end
      sym = AminoTable[row];
      for (s = 0; s < cwc_pkg::NumAmino; s++) begin
         if (AminoOrder[s] == sym) return s;
      end
      return cwc_pkg::NumAmino;
   endfunction

   function automatic logic [16:0] clamp17(int v);
      return (v > 131071) ? 17'h1FFFF : 17'(v);
   endfunction

   function automatic composition_type make_beat(int feat, int num, int den);
      composition_type r;
      r.feature      = 5'(feat);
      r.numerator    = clamp17(num);
      r.denominator  = clamp17(den);
      r.out_of_range = 1'b0;
      r.last         = (feat == cwc_pkg::NumResults - 1);
      return r;
   endfunction

   task automatic predict_composition(request_type rq);
      int              lo, hi, p, total, nucs, slot, tmp;
      int              amino_cnt [cwc_pkg::NumAmino];
      int              win_cnt [5];
      logic [7:0]      b0, b1, b2;
      composition_type oor;
      p = int'(rq.position);
      case (rq.op)
         cwc_pkg::OP_APPEND: begin
            if (seq_len < SeqCap) begin
               seq_mem[seq_len] = rq.base;
               seq_len++;
               whole_counts[nucleotide_code(rq.base)]++;
            end
         end
         cwc_pkg::OP_CLEAR: begin
            seq_len = 0;
            whole_counts = '{default: 0};
         end
         cwc_pkg::OP_QUERY: begin
            if (p + 2 >= seq_len) begin
               oor = '{feature: cwc_pkg::FEAT_GC, numerator: 0, denominator: 0,
                       out_of_range: 1'b1, last: 1'b1};
               expected_beats.push_back(oor);
            end else begin
               amino_cnt = '{default: 0};
               win_cnt = '{default: 0};
               lo = ((p > BackSpan + p % 3) ? p : BackSpan + p % 3) - BackSpan;
               hi = seq_len - 2;
               if (p + AheadSpan < hi) hi = p + AheadSpan;
               total = 0;
               for (int i = lo; i < hi; i += 3) begin
                  b0 = seq_mem[i];
                  b1 = seq_mem[i+1];
                  b2 = seq_mem[i+2];
                  if (rq.strand) slot = codon_slot(b0, b1, b2);
                  else slot = codon_slot(pair_base(b2), pair_base(b1), pair_base(b0));
                  if (slot < cwc_pkg::NumAmino) amino_cnt[slot]++;
                  win_cnt[nucleotide_code(b0)]++;
                  win_cnt[nucleotide_code(b1)]++;
                  win_cnt[nucleotide_code(b2)]++;
                  total++;
               end
               // Reverse strand reports complement bases.
               if (!rq.strand) begin
                  tmp = win_cnt[0]; win_cnt[0] = win_cnt[3]; win_cnt[3] = tmp;
                  tmp = win_cnt[1]; win_cnt[1] = win_cnt[2]; win_cnt[2] = tmp;
               end
               nucs = win_cnt[0] + win_cnt[1] + win_cnt[2] + win_cnt[3];
               expected_beats.push_back(make_beat(0, whole_counts[1] + whole_counts[2],
                  whole_counts[0] + whole_counts[1] + whole_counts[2] + whole_counts[3]));
               for (int k = 0; k < 4; k++)
                  expected_beats.push_back(make_beat(1 + k, win_cnt[k], nucs));
               expected_beats.push_back(make_beat(5, total, 1));
               for (int k = 0; k < cwc_pkg::NumAmino; k++)
                  expected_beats.push_back(make_beat(6 + k, amino_cnt[k], total));
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request driver: bursts of beats separated by random gaps.
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      request_type rq;
      bit          busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid;
         if (req_valid && req_ready) begin
            predict_composition('{op: req_op, base: req_base, position: req_position,
                                  strand: req_strand, hold: 1'b0});
            busy = 1'b0;
         end
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].hold || expected_beats.size() == 0)) begin
               rq = pending_reqs.pop_front();
               req_op       <= rq.op;
               req_base     <= rq.base;
               req_position <= rq.position;
               req_strand   <= rq.strand;
               busy = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_valid <= busy;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor and consumer stall pattern.
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;

   always @(posedge clock) begin
      composition_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: feature %0d", rsp_feature);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_feature !== want.feature) begin
                  $error("feature: expected %0d, got %0d", want.feature, rsp_feature);
                  error_count++;
               end
               if (rsp_numerator !== want.numerator) begin
                  $error("numerator: expected %0d, got %0d", want.numerator, rsp_numerator);
                  error_count++;
               end
               if (rsp_denominator !== want.denominator) begin
                  $error("denominator: expected %0d, got %0d",
                         want.denominator, rsp_denominator);
                  error_count++;
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, got %0d",
                         want.out_of_range, rsp_out_of_range);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  error_count++;
               end
            end
         end
         // Switch between always ready, coin flip and mostly stalled.
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(8, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   int plan_len = 0;

   task automatic add_req(logic [1:0] op, logic [7:0] b, int pos, logic s, bit hold = 0);
      request_type rq;
      rq = '{op: op, base: b, position: 16'(pos), strand: s, hold: hold};
      pending_reqs.push_back(rq);
      if (op == cwc_pkg::OP_APPEND && plan_len < SeqCap) plan_len++;
      if (op == cwc_pkg::OP_CLEAR) plan_len = 0;
   endtask

   function automatic logic [7:0] pick_byte();
      string acgt, ambig;
      acgt  = "acgt";
      ambig = "nrykmbvdhswx";
      case ($urandom_range(0, 9))
         7:       return ambig[$urandom_range(0, 11)];
         8:       return 8'($urandom_range(0, 255));
         9:       return 8'h61 + 8'($urandom_range(0, 25));
         default: return acgt[$urandom_range(0, 3)];
      endcase
   endfunction

   initial begin
      string dir_bytes;
      int    pos, n;
      whole_counts = '{default: 0};
      dir_bytes = "acgtacgtnrykatgtaa";

      // Directed: empty store, extremes, every op, ambiguity and strands.
      add_req(cwc_pkg::OP_QUERY, 8'h00, 0, 1'b1);
      add_req(cwc_pkg::OP_QUERY, 8'hFF, 16'hFFFF, 1'b0);
      add_req(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
      for (int i = 0; i < dir_bytes.len(); i++)
         add_req(cwc_pkg::OP_APPEND, dir_bytes[i], 0, 1'b0);
      add_req(cwc_pkg::OP_APPEND, 8'h00, 0, 1'b0);
      add_req(cwc_pkg::OP_APPEND, 8'hFF, 0, 1'b0);
      add_req(cwc_pkg::OP_QUERY, 8'h00, 0, 1'b1);
      add_req(cwc_pkg::OP_QUERY, 8'h00, 0, 1'b0);
      add_req(cwc_pkg::OP_QUERY, 8'h00, plan_len - 3, 1'b1);
      add_req(cwc_pkg::OP_QUERY, 8'h00, plan_len - 2, 1'b0);
      add_req(cwc_pkg::OP_CLEAR, 8'h00, 0, 1'b0);
      add_req(cwc_pkg::OP_QUERY, 8'h00, 0, 1'b1);

      // Random: append runs with mixed content, queries over the window.
      n = 0;
      while (n < 180) begin
         case ($urandom_range(0, 19))
            0: add_req(cwc_pkg::OP_CLEAR, pick_byte(), $urandom_range(0, 65535),
                       $urandom_range(0, 1));
            1: add_req(OP_UNUSED, pick_byte(), $urandom_range(0, 65535),
                       $urandom_range(0, 1));
            2, 3, 4, 5: begin
               repeat ($urandom_range(5, 60)) begin
                  add_req(cwc_pkg::OP_APPEND, pick_byte(), $urandom_range(0, 65535),
                          $urandom_range(0, 1));
                  n++;
               end
            end
            6: add_req(cwc_pkg::OP_QUERY, pick_byte(), $urandom_range(0, 65535),
                       $urandom_range(0, 1));
            default: begin
               pos = (plan_len > 0) ? $urandom_range(0, plan_len + 1) : 0;
               add_req(cwc_pkg::OP_QUERY, pick_byte(), pos, $urandom_range(0, 1),
                       n > 90 && n < 110);
            end
         endcase
         n++;
      end

      // Fresh short sequence after a drained pipeline, queries at its end, its start and past it.
      add_req(cwc_pkg::OP_CLEAR, 8'h00, 0, 1'b0, 1'b1);
      for (int i = 0; i < 9; i++) add_req(cwc_pkg::OP_APPEND, pick_byte(), 0, 1'b0);
      add_req(cwc_pkg::OP_QUERY, 8'h00, plan_len - 3, 1'b1);
      add_req(cwc_pkg::OP_QUERY, 8'h00, plan_len - 3, 1'b0);
      add_req(cwc_pkg::OP_QUERY, 8'h00, 0, 1'b0);
      add_req(cwc_pkg::OP_QUERY, 8'h00, 65535, 1'b1);
      stimulus_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Reset, end of run and timeout
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      while (pending_reqs.size() > 0 || req_valid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/cwc_pkg.sv
hw/rtl/cwc_seq_mem.sv
hw/rtl/codon_window_composition.sv
test/codon_window_composition_tb.sv
